[hw/rtl/clcd_pkg.sv]
// ----------------------------------------------------------------------------
// clcd_pkg
// Shared types, codes, constants and the decimal adjust step for the
// character-LCD command formatter.
// ----------------------------------------------------------------------------
package clcd_pkg;

  // digit slots and display geometry
  localparam int DIGIT_SLOTS   = 20;
  localparam int BCD_W         = 4 * DIGIT_SLOTS;
  localparam int VALUE_W       = 64;
  localparam int COLUMN_COUNT  = 16;
  localparam int BITS_PER_STEP = 4;
  localparam int CONV_STEPS    = VALUE_W / BITS_PER_STEP;
  localparam int STEP_W        = $clog2(CONV_STEPS);
  localparam int REMAIN_W      = $clog2(DIGIT_SLOTS + 1);

  // lcd command bytes
  localparam logic [7:0] CMD_CLEAR  = 8'h01;
  localparam logic [7:0] ROW0_BASE  = 8'h80;
  localparam logic [7:0] ROW1_BASE  = 8'hC0;
  localparam logic [7:0] ASCII_ZERO = 8'h30;

  // register select values
  localparam logic RS_INSTR = 1'b0;
  localparam logic RS_DATA  = 1'b1;

  // request codes
  typedef enum logic [2:0] {
    ACT_INIT   = 3'd0,
    ACT_CLEAR  = 3'd1,
    ACT_CHAR   = 3'd2,
    ACT_NUMBER = 3'd3,
    ACT_MOVE   = 3'd4
  } action_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_FUNCTION_SET    = 2'd0,
    REG_DISPLAY_CONTROL = 2'd1,
    REG_ENTRY_MODE      = 2'd2
  } reg_idx_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EMIT,
    S_CONV,
    S_SKIP,
    S_NUM
  } state_t;

  // control from the sequencer to the converter
  typedef struct packed {
    logic load;
    logic shift;
  } conv_ctrl_t;

  // status from the converter to the sequencer
  typedef struct packed {
    logic       busy;
    logic [3:0] top_digit;
  } conv_stat_t;

  // one shift-and-add-3 step: adjust every digit, then shift in one bit
  function automatic logic [BCD_W-1:0] dabble_bit(input logic [BCD_W-1:0] bcd,
                                                  input logic             b);
    logic [BCD_W-1:0] adj;
    logic [3:0]       d;
    for (int i = 0; i < DIGIT_SLOTS; i++) begin
      d = bcd[4*i +: 4];
      adj[4*i +: 4] = (d >= 4'd5) ? 4'(d + 4'd3) : d;
    end
    return {adj[BCD_W-2:0], b};
  endfunction

endpackage

[hw/rtl/char_lcd_command_formatter.sv]
// ----------------------------------------------------------------------------
// char_lcd_command_formatter
// Turns character-LCD requests into runs of register-select/byte bus writes.
// ----------------------------------------------------------------------------
// One request at a time. Init gives four writes, clear, write char and move
// cursor give one, a bad cursor position or an unknown request gives none and
// frees the input after the accepting cycle. Fixed runs put out one write a
// cycle while the output is not stalled. Write number runs a binary to decimal
// converter that handles four bits a cycle, then drops the leading zero digits
// of the 20-digit field, keeping at least one, and prints the rest most
// significant first. The input is not ready while a run is in progress; one
// output register holds the write that waits.
module char_lcd_command_formatter (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  // action[2:0], char_code[10:3], number_value[74:11], column[82:75],
  // row[90:83], zero [95:91]
  input  logic [95:0] in_tdata,
  // output channel
  output logic        out_tvalid,
  input  logic        out_tready,
  // bus_byte[7:0]
  output logic [7:0]  out_tdata,
  // register_select[0]
  output logic        out_tuser,
  output logic        out_tlast,
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // input fields
  logic [2:0]                   in_action;
  logic [7:0]                   in_char_code;
  logic [clcd_pkg::VALUE_W-1:0] in_number_value;
  logic [7:0]                   in_column;
  logic [7:0]                   in_row;

  assign in_action       = in_tdata[2:0];
  assign in_char_code    = in_tdata[10:3];
  assign in_number_value = in_tdata[74:11];
  assign in_column       = in_tdata[82:75];
  assign in_row          = in_tdata[90:83];

  // configuration registers
  logic [7:0] func_set_r, disp_ctrl_r, entry_mode_r;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      func_set_r   <= 8'h38;
      disp_ctrl_r  <= 8'h0C;
      entry_mode_r <= 8'h06;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        clcd_pkg::REG_FUNCTION_SET:    func_set_r   <= cfg_pwdata[7:0];
        clcd_pkg::REG_DISPLAY_CONTROL: disp_ctrl_r  <= cfg_pwdata[7:0];
        clcd_pkg::REG_ENTRY_MODE:      entry_mode_r <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (cfg_paddr[3:2])
      clcd_pkg::REG_FUNCTION_SET:    cfg_prdata = {24'd0, func_set_r};
      clcd_pkg::REG_DISPLAY_CONTROL: cfg_prdata = {24'd0, disp_ctrl_r};
      clcd_pkg::REG_ENTRY_MODE:      cfg_prdata = {24'd0, entry_mode_r};
      default:                       cfg_prdata = 32'd0;
    endcase
  end

  // sequencer registers
  clcd_pkg::state_t               state_r, state_nxt;
  logic                           is_init_r, is_init_nxt;
  logic [1:0]                     idx_r, idx_nxt;
  logic [1:0]                     last_idx_r, last_idx_nxt;
  logic [7:0]                     byte_r, byte_nxt;
  logic                           rs_r, rs_nxt;
  logic [clcd_pkg::REMAIN_W-1:0]  remain_r, remain_nxt;

  // output register
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_rs_r, out_rs_nxt;
  logic       out_last_r, out_last_nxt;

  logic                 in_xfer, emit_ok, col_ok;
  logic [7:0]           init_byte;
  clcd_pkg::conv_ctrl_t conv_ctrl;
  clcd_pkg::conv_stat_t conv_stat;

  assign in_tready = (state_r == clcd_pkg::S_IDLE);
  assign in_xfer   = in_tvalid & in_tready;
  assign emit_ok   = !out_valid_r || out_tready;
  assign col_ok    = (in_column < 8'(clcd_pkg::COLUMN_COUNT));

  // decimal converter
  clcd_dabble u_dabble (
    .clk   (clk),
    .rst_n (rst_n),
    .value (in_number_value),
    .ctrl  (conv_ctrl),
    .stat  (conv_stat)
  );

  // init run byte by position
  always_comb begin
    case (idx_r)
      2'd0:    init_byte = clcd_pkg::CMD_CLEAR;
      2'd1:    init_byte = func_set_r;
      2'd2:    init_byte = disp_ctrl_r;
      default: init_byte = entry_mode_r;
    endcase
  end

  // next state and outputs
  always_comb begin
    state_nxt      = state_r;
    is_init_nxt    = is_init_r;
    idx_nxt        = idx_r;
    last_idx_nxt   = last_idx_r;
    byte_nxt       = byte_r;
    rs_nxt         = rs_r;
    remain_nxt     = remain_r;
    conv_ctrl      = '0;
    out_valid_nxt  = out_valid_r & ~out_tready;
    out_byte_nxt   = out_byte_r;
    out_rs_nxt     = out_rs_r;
    out_last_nxt   = out_last_r;

    case (state_r)
      clcd_pkg::S_IDLE: begin
        if (in_xfer) begin
          idx_nxt      = 2'd0;
          last_idx_nxt = 2'd0;
          is_init_nxt  = 1'b0;
          rs_nxt       = clcd_pkg::RS_INSTR;
          case (in_action)
            clcd_pkg::ACT_INIT: begin
              is_init_nxt  = 1'b1;
              last_idx_nxt = 2'd3;
              state_nxt    = clcd_pkg::S_EMIT;
            end
            clcd_pkg::ACT_CLEAR: begin
              byte_nxt  = clcd_pkg::CMD_CLEAR;
              state_nxt = clcd_pkg::S_EMIT;
            end
            clcd_pkg::ACT_CHAR: begin
              byte_nxt  = in_char_code;
              rs_nxt    = clcd_pkg::RS_DATA;
              state_nxt = clcd_pkg::S_EMIT;
            end
            clcd_pkg::ACT_NUMBER: begin
              conv_ctrl.load = 1'b1;
              state_nxt      = clcd_pkg::S_CONV;
            end
            clcd_pkg::ACT_MOVE: begin
              if (col_ok && in_row == 8'd0) begin
                byte_nxt  = clcd_pkg::ROW0_BASE + in_column;
                state_nxt = clcd_pkg::S_EMIT;
              end else if (col_ok && in_row == 8'd1) begin
                byte_nxt  = clcd_pkg::ROW1_BASE + in_column;
                state_nxt = clcd_pkg::S_EMIT;
              end
            end
            default: ;
          endcase
        end
      end

      // fixed runs, one write per free output slot
      clcd_pkg::S_EMIT: begin
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = is_init_r ? init_byte : byte_r;
          out_rs_nxt    = rs_r;
          out_last_nxt  = (idx_r == last_idx_r);
          idx_nxt       = idx_r + 1'b1;
          if (idx_r == last_idx_r) begin
            state_nxt = clcd_pkg::S_IDLE;
          end
        end
      end

      // wait for the converter
      clcd_pkg::S_CONV: begin
        if (!conv_stat.busy) begin
          remain_nxt = clcd_pkg::REMAIN_W'(clcd_pkg::DIGIT_SLOTS);
          state_nxt  = clcd_pkg::S_SKIP;
        end
      end

      // drop leading zero digits, keep at least one
      clcd_pkg::S_SKIP: begin
        if (conv_stat.top_digit == 4'd0 && remain_r > clcd_pkg::REMAIN_W'(1)) begin
          conv_ctrl.shift = 1'b1;
          remain_nxt      = remain_r - 1'b1;
        end else begin
          state_nxt = clcd_pkg::S_NUM;
        end
      end

      // print digits most significant first
      clcd_pkg::S_NUM: begin
        if (emit_ok) begin
          out_valid_nxt   = 1'b1;
          out_byte_nxt    = clcd_pkg::ASCII_ZERO + {4'd0, conv_stat.top_digit};
          out_rs_nxt      = clcd_pkg::RS_DATA;
          out_last_nxt    = (remain_r == clcd_pkg::REMAIN_W'(1));
          conv_ctrl.shift = 1'b1;
          remain_nxt      = remain_r - 1'b1;
          if (remain_r == clcd_pkg::REMAIN_W'(1)) begin
            state_nxt = clcd_pkg::S_IDLE;
          end
        end
      end

      default: state_nxt = clcd_pkg::S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= clcd_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      is_init_r   <= 1'b0;
      idx_r       <= 2'd0;
      last_idx_r  <= 2'd0;
      remain_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      is_init_r   <= is_init_nxt;
      idx_r       <= idx_nxt;
      last_idx_r  <= last_idx_nxt;
      remain_r    <= remain_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    rs_r       <= rs_nxt;
    out_byte_r <= out_byte_nxt;
    out_rs_r   <= out_rs_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_rs_r;
  assign out_tlast  = out_last_r;

endmodule

[hw/rtl/clcd_dabble.sv]
// ----------------------------------------------------------------------------
// clcd_dabble
// Binary to decimal converter: shift-and-add-3 over four bits per cycle,
// then hands out digits most significant first on request.
// ----------------------------------------------------------------------------
module clcd_dabble (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [clcd_pkg::VALUE_W-1:0]  value,
  input  clcd_pkg::conv_ctrl_t          ctrl,
  output clcd_pkg::conv_stat_t          stat
);

  logic [clcd_pkg::VALUE_W-1:0] bin_r, bin_nxt;
  logic [clcd_pkg::BCD_W-1:0]   bcd_r, bcd_nxt;
  logic [clcd_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic                         busy_r, busy_nxt;
  logic [clcd_pkg::BCD_W-1:0]   bcd_s [clcd_pkg::BITS_PER_STEP+1];

  // four dependent adjust steps per cycle
  always_comb begin
    bcd_s[0] = bcd_r;
    for (int k = 0; k < clcd_pkg::BITS_PER_STEP; k++) begin
      bcd_s[k+1] = clcd_pkg::dabble_bit(bcd_s[k], bin_r[clcd_pkg::VALUE_W-1-k]);
    end
  end

  // load, convert, or shift a digit out
  always_comb begin
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    if (ctrl.load) begin
      bin_nxt  = value;
      bcd_nxt  = '0;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      bin_nxt  = bin_r << clcd_pkg::BITS_PER_STEP;
      bcd_nxt  = bcd_s[clcd_pkg::BITS_PER_STEP];
      step_nxt = step_r + 1'b1;
      if (step_r == clcd_pkg::STEP_W'(clcd_pkg::CONV_STEPS - 1)) begin
        busy_nxt = 1'b0;
      end
    end else if (ctrl.shift) begin
      bcd_nxt = bcd_r << 4;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign stat.busy      = busy_r;
  assign stat.top_digit = bcd_r[clcd_pkg::BCD_W-1 -: 4];

endmodule

[hw/rtl/clcd_checker.sv]
// ----------------------------------------------------------------------------
// clcd_checker
// Port-level checks on the character-LCD command formatter.
// ----------------------------------------------------------------------------
module clcd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [95:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  logic in_xfer;
  assign in_xfer = in_tvalid & in_tready;

  // a stalled write holds its contents
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("output write changed while stalled");

  // while a run is open the input stays closed
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input ready in the middle of a run");

  // a clear request always starts a run
  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_tdata[2:0] == clcd_pkg::ACT_CLEAR |=> !in_tready)
    else $error("clear request produced no run");

  // unknown requests leave the block idle
  a_unknown_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_tdata[2:0] > clcd_pkg::ACT_MOVE |=> in_tready)
    else $error("unknown request occupied the block");

endmodule

bind char_lcd_command_formatter clcd_checker u_clcd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

[tb/char_lcd_command_formatter_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// char_lcd_command_formatter_test
// Self-checking bench for the character-LCD command formatter. Requests go
// in on the input stream, and a behavioral model of the command runs predicts
// each bus write. The writes that come out are checked in order against those
// predictions. Both stream sides stall at random, and the init command bytes
// are rewritten over the APB port between phases.
// ----------------------------------------------------------------------------
module char_lcd_command_formatter_test;

  localparam int          CLK_HALF      = 4;
  localparam int          RESET_CYCLES  = 7;
  localparam int          SETTLE_CYCLES = 64;
  localparam int          CYCLE_LIMIT   = 400000;
  localparam int          IDLE_PCT      = 27;
  localparam int          RANDOM_WRITES = 340;
  localparam int          MAX_REPORTS   = 10;
  localparam logic [2:0]  ACT_RSVD_LO   = 3'd5;
  localparam logic [2:0]  ACT_RSVD_HI   = 3'd7;
  localparam logic [63:0] MAX_VALUE     = 64'hFFFF_FFFF_FFFF_FFFF;

  // one bus write as it leaves the block
  typedef struct packed {
    logic       rs;
    logic [7:0] bus_byte;
    logic       last;
  } lcd_write_t;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata    = '0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [3:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // shadow copy of the init command bytes
  logic [7:0] function_set_shadow    = 8'h38;
  logic [7:0] display_control_shadow = 8'h0C;
  logic [7:0] entry_mode_shadow      = 8'h06;

  lcd_write_t pending_writes[$];
  bit         steady      = 1'b0;
  int         mismatches  = 0;
  int         cycles      = 0;
  int         requests    = 0;
  int         writes_seen = 0;
  int         numbers     = 0;
  int         reg_writes  = 0;

  char_lcd_command_formatter dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #(CLK_HALF) clk = ~clk;

  // run guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d writes still pending", cycles,
               pending_writes.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  function automatic void note_mismatch(string what, logic [31:0] exp_v,
                                        logic [31:0] act_v);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch at cycle %0d: %s expected 0x%0h got 0x%0h", cycles,
               what, exp_v, act_v);
  endfunction

  // check each write transfer against the oldest prediction
  always @(posedge clk) begin
    lcd_write_t exp_w;
    if (rst_n && out_tvalid && out_tready) begin
      writes_seen++;
      if (pending_writes.size() == 0) begin
        note_mismatch("unexpected write {rs,byte,last}", 32'h0,
                      {22'b0, out_tuser, out_tdata, out_tlast});
      end else begin
        exp_w = pending_writes.pop_front();
        if (out_tuser !== exp_w.rs)
          note_mismatch("register_select", 32'(exp_w.rs), 32'(out_tuser));
        if (out_tdata !== exp_w.bus_byte)
          note_mismatch("bus_byte", 32'(exp_w.bus_byte), 32'(out_tdata));
        if (out_tlast !== exp_w.last)
          note_mismatch("last", 32'(exp_w.last), 32'(out_tlast));
      end
    end
  end

  // expected write run for one request; returns the number of writes
  function automatic int predict_writes(logic [2:0] act, logic [7:0] ch,
                                        logic [63:0] num, logic [7:0] col,
                                        logic [7:0] row);
    logic       rs_l[clcd_pkg::DIGIT_SLOTS];
    logic [7:0] byte_l[clcd_pkg::DIGIT_SLOTS];
    logic [7:0] digits[clcd_pkg::DIGIT_SLOTS];
    logic [63:0] rest;
    lcd_write_t w;
    int n;
    int nd;
    n = 0;
    case (act)
      clcd_pkg::ACT_INIT: begin
        rs_l[0] = clcd_pkg::RS_INSTR; byte_l[0] = clcd_pkg::CMD_CLEAR;
        rs_l[1] = clcd_pkg::RS_INSTR; byte_l[1] = function_set_shadow;
        rs_l[2] = clcd_pkg::RS_INSTR; byte_l[2] = display_control_shadow;
        rs_l[3] = clcd_pkg::RS_INSTR; byte_l[3] = entry_mode_shadow;
        n = 4;
      end
      clcd_pkg::ACT_CLEAR: begin
        rs_l[0] = clcd_pkg::RS_INSTR; byte_l[0] = clcd_pkg::CMD_CLEAR;
        n = 1;
      end
      clcd_pkg::ACT_CHAR: begin
        rs_l[0] = clcd_pkg::RS_DATA; byte_l[0] = ch;
        n = 1;
      end
      clcd_pkg::ACT_NUMBER: begin
        // split into decimal digits, least significant first
        rest = num;
        nd = 0;
        do begin
          digits[nd] = clcd_pkg::ASCII_ZERO + 8'(rest % 64'd10);
          nd++;
          rest = rest / 64'd10;
        end while (rest != 0);
        for (int k = nd - 1; k >= 0; k--) begin
          rs_l[n] = clcd_pkg::RS_DATA; byte_l[n] = digits[k];
          n++;
        end
      end
      clcd_pkg::ACT_MOVE: begin
        if (col < clcd_pkg::COLUMN_COUNT && row == 8'd0) begin
          rs_l[0] = clcd_pkg::RS_INSTR; byte_l[0] = clcd_pkg::ROW0_BASE + col;
          n = 1;
        end else if (col < clcd_pkg::COLUMN_COUNT && row == 8'd1) begin
          rs_l[0] = clcd_pkg::RS_INSTR; byte_l[0] = clcd_pkg::ROW1_BASE + col;
          n = 1;
        end
      end
      default: n = 0;
    endcase
    for (int i = 0; i < n; i++) begin
      w.rs       = rs_l[i];
      w.bus_byte = byte_l[i];
      w.last     = (i == n - 1);
      pending_writes.push_back(w);
    end
    return n;
  endfunction

  // send one request; returns right after its transfer with valid still high
  task automatic send_request(input logic [2:0] act, input logic [7:0] ch,
                              input logic [63:0] num, input logic [7:0] col,
                              input logic [7:0] row, output int n_writes);
    n_writes = predict_writes(act, ch, num, col, row);
    requests++;
    if (act == clcd_pkg::ACT_NUMBER) numbers++;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, row, col, num, ch, act};
    do @(posedge clk); while (!in_tready);
  endtask

  // fire and forget variant for directed items
  task automatic send(input logic [2:0] act, input logic [7:0] ch,
                      input logic [63:0] num, input logic [7:0] col,
                      input logic [7:0] row);
    int n;
    send_request(act, ch, num, col, row, n);
  endtask

  // hold off the sender until all writes are back and the block is quiet
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // apb write then read back
  task automatic write_reg(input clcd_pkg::reg_idx_t idx, input logic [7:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 4'(4 * idx);
    cfg_pwdata  <= {8'($urandom_range(255)), 8'($urandom_range(255)),
                    8'($urandom_range(255)), val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      clcd_pkg::REG_FUNCTION_SET:    function_set_shadow    = val;
      clcd_pkg::REG_DISPLAY_CONTROL: display_control_shadow = val;
      default:                       entry_mode_shadow      = val;
    endcase
    reg_writes++;
    // read back
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== {24'b0, val})
      note_mismatch("register read back", {24'b0, val}, cfg_prdata);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_init_bytes(input logic [7:0] fs, input logic [7:0] dc,
                                  input logic [7:0] em);
    write_reg(clcd_pkg::REG_FUNCTION_SET, fs);
    write_reg(clcd_pkg::REG_DISPLAY_CONTROL, dc);
    write_reg(clcd_pkg::REG_ENTRY_MODE, em);
  endtask

  function automatic logic [63:0] rand_u64();
    return {$urandom(), $urandom()};
  endfunction

  // init with the reset values of the command bytes
  task automatic test_reset_values();
    send(clcd_pkg::ACT_INIT, 8'h00, 64'd0, 8'd0, 8'd0);
    wait_idle();
  endtask

  // clear, character extremes and unknown request codes
  task automatic test_fixed_runs();
    send(clcd_pkg::ACT_CLEAR, 8'hFF, MAX_VALUE, 8'hFF, 8'hFF);
    send(clcd_pkg::ACT_CHAR, 8'h00, 64'd0, 8'd0, 8'd0);
    send(clcd_pkg::ACT_CHAR, 8'hFF, MAX_VALUE, 8'hFF, 8'hFF);
    send(clcd_pkg::ACT_CHAR, 8'hA5, 64'd0, 8'd0, 8'd0);
    send(clcd_pkg::ACT_CHAR, 8'h5A, 64'd0, 8'd0, 8'd0);
    // unknown codes produce nothing
    send(ACT_RSVD_LO, 8'hFF, MAX_VALUE, 8'd0, 8'd0);
    send(ACT_RSVD_HI, 8'h41, 64'd12345, 8'd3, 8'd1);
    send(clcd_pkg::ACT_CLEAR, 8'h00, 64'd0, 8'd0, 8'd0);
    wait_idle();
  endtask

  // zero, single digits, powers of ten and the 20-digit maximum
  task automatic test_number_edges();
    send(clcd_pkg::ACT_NUMBER, 8'h00, 64'd0, 8'd0, 8'd0);
    send(clcd_pkg::ACT_NUMBER, 8'h00, 64'd1, 8'd0, 8'd0);
    send(clcd_pkg::ACT_NUMBER, 8'h00, 64'd9, 8'd0, 8'd0);
    send(clcd_pkg::ACT_NUMBER, 8'h00, 64'd10, 8'd0, 8'd0);
    send(clcd_pkg::ACT_NUMBER, 8'h00, 64'd10000000000000000000, 8'd0, 8'd0);
    send(clcd_pkg::ACT_NUMBER, 8'h00, 64'h8000_0000_0000_0000, 8'd0, 8'd0);
    send(clcd_pkg::ACT_NUMBER, 8'hFF, MAX_VALUE, 8'hFF, 8'hFF);
    wait_idle();
  endtask

  // cursor corners on both rows plus bad rows and columns
  task automatic test_cursor_moves();
    send(clcd_pkg::ACT_MOVE, 8'h00, 64'd0, 8'd0, 8'd0);
    send(clcd_pkg::ACT_MOVE, 8'h00, 64'd0, 8'(clcd_pkg::COLUMN_COUNT - 1), 8'd0);
    send(clcd_pkg::ACT_MOVE, 8'h00, 64'd0, 8'd0, 8'd1);
    send(clcd_pkg::ACT_MOVE, 8'hFF, MAX_VALUE, 8'(clcd_pkg::COLUMN_COUNT - 1), 8'd1);
    // no writes for the first four of these; the last is a legal move
    send(clcd_pkg::ACT_MOVE, 8'h00, 64'd0, 8'(clcd_pkg::COLUMN_COUNT), 8'd0);
    send(clcd_pkg::ACT_MOVE, 8'h00, 64'd0, 8'hFF, 8'd1);
    send(clcd_pkg::ACT_MOVE, 8'h00, 64'd0, 8'd5, 8'd2);
    send(clcd_pkg::ACT_MOVE, 8'h00, 64'd0, 8'd5, 8'hFF);
    send(clcd_pkg::ACT_MOVE, 8'h00, 64'd0, 8'd7, 8'd1);
    wait_idle();
  endtask

  // init bytes at all-zero, all-one and random settings
  task automatic test_register_extremes();
    write_init_bytes(8'h00, 8'h00, 8'h00);
    send(clcd_pkg::ACT_INIT, 8'h00, 64'd0, 8'd0, 8'd0);
    wait_idle();
    write_init_bytes(8'hFF, 8'hFF, 8'hFF);
    send(clcd_pkg::ACT_INIT, 8'h00, 64'd0, 8'd0, 8'd0);
    wait_idle();
    write_init_bytes(8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(255)));
    send(clcd_pkg::ACT_INIT, 8'h00, 64'd0, 8'd0, 8'd0);
    wait_idle();
  endtask

  // one random request from a weighted mix
  task automatic send_random(output int n_writes);
    logic [2:0]  act;
    logic [7:0]  col;
    logic [7:0]  row;
    logic [63:0] num;
    int          pick;
    pick = $urandom_range(99);
    col  = 8'($urandom_range(255));
    row  = 8'($urandom_range(255));
    num  = rand_u64();
    if (pick < 10) act = clcd_pkg::ACT_INIT;
    else if (pick < 20) act = clcd_pkg::ACT_CLEAR;
    else if (pick < 45) act = clcd_pkg::ACT_CHAR;
    else if (pick < 75) act = clcd_pkg::ACT_NUMBER;
    else if (pick < 95) act = clcd_pkg::ACT_MOVE;
    else act = 3'($urandom_range(ACT_RSVD_LO, ACT_RSVD_HI));
    // spread digit counts over the whole range
    if (act == clcd_pkg::ACT_NUMBER) begin
      if ($urandom_range(9) == 0) num = MAX_VALUE >> $urandom_range(3);
      else num = num >> $urandom_range(63);
    end
    // mostly legal cursor positions
    if (act == clcd_pkg::ACT_MOVE && $urandom_range(3) != 0) begin
      col = 8'($urandom_range(clcd_pkg::COLUMN_COUNT - 1));
      row = 8'($urandom_range(1));
    end
    send_request(act, 8'($urandom_range(255)), num, col, row, n_writes);
  endtask

  // random mix with a pause, a mid-run register change and a no-stall stretch
  task automatic test_random_requests();
    int n;
    int counted;
    counted = 0;
    while (counted < RANDOM_WRITES) begin
      if (counted == RANDOM_WRITES / 2) begin
        wait_idle();
        write_init_bytes(8'($urandom_range(255)), 8'($urandom_range(255)),
                         8'($urandom_range(255)));
        counted++;
      end
      steady = (counted >= RANDOM_WRITES / 2 + 20) &&
               (counted < RANDOM_WRITES / 2 + 100);
      send_random(n);
      if (n > 0) counted++;
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_fixed_runs();
    test_number_edges();
    test_cursor_moves();
    test_register_extremes();
    test_random_requests();
    wait_idle();
    $display("covered %0d requests (%0d numbers) and %0d bus writes,", requests,
             numbers, writes_seen);
    $display("with %0d register writes and random stalls on both streams", reg_writes);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/clcd_pkg.sv
hw/rtl/clcd_dabble.sv
hw/rtl/char_lcd_command_formatter.sv
hw/rtl/clcd_checker.sv
tb/char_lcd_command_formatter_test.sv
